// ===== hdl/mts_pkg.sv =====
`default_nettype none

package mts_pkg;

    // default depth of the stack
    localparam int STACK_DEPTH_DEF = 1024;

    // widths fixed by the item fields
    localparam int VAL_W   = 32;
    localparam int CODE_W  = 34;
    localparam int COUNT_W = 11;

    // command codes
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_FINISH
    } mts_state_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic load;
        logic finish;
    } mts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_load;
        logic out_free;
    } mts_stat_t;

endpackage

`default_nettype wire

// ===== hdl/mts_ctrl.sv =====
`default_nettype none

module mts_ctrl
    import mts_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire mts_stat_t stat,
    output mts_cmd_t       cmd
);

    mts_state_t state_reg;
    mts_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.needs_load)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/mts_datapath.sv =====
`default_nettype none

module mts_datapath
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mts_cmd_t                  cmd,
    output mts_stat_t                      stat,
    input  wire logic [1:0]                command,
    input  wire logic signed [VAL_W-1:0]   push_value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [VAL_W-1:0]        popped_value,
    output logic signed [VAL_W-1:0]        top_value,
    output logic signed [VAL_W-1:0]        min_value,
    output logic [COUNT_W-1:0]             entry_count,
    output logic [1:0]                     status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // entries below the top; the top code lives in top_reg
    logic signed [CODE_W-1:0] mem [STACK_DEPTH];

    logic [1:0]               cmd_reg;
    logic signed [VAL_W-1:0]  val_reg;
    logic signed [CODE_W-1:0] top_reg, top_next;
    logic signed [CODE_W-1:0] rd_data_reg;
    logic signed [VAL_W-1:0]  min_reg, min_next;
    logic [CW-1:0]            count_reg, count_next;
    logic signed [VAL_W-1:0]  popped_reg, popped_next;
    logic [1:0]               status_reg, status_next;

    logic                     out_valid_reg;
    logic signed [VAL_W-1:0]  popped_out_reg;
    logic signed [VAL_W-1:0]  top_out_reg;
    logic signed [VAL_W-1:0]  min_out_reg;
    logic [COUNT_W-1:0]       count_out_reg;
    logic [1:0]               status_out_reg;

    logic [CW-1:0]            cnt_m1;
    logic [CW-1:0]            cnt_m2;
    logic                     empty;
    logic                     full;
    logic signed [CODE_W-1:0] min_ext;
    logic signed [CODE_W-1:0] val_ext;
    logic signed [CODE_W-1:0] push_code;
    logic signed [CODE_W-1:0] min_restore;
    logic                     top_ge_min;
    logic signed [VAL_W-1:0]  top_dec;
    logic                     mem_we;
    logic                     mem_re;

    // helpers on the current state
    assign cnt_m1      = count_reg - CW'(1);
    assign cnt_m2      = count_reg - CW'(2);
    assign empty       = (count_reg == '0);
    assign full        = (count_reg == CW'(STACK_DEPTH));
    assign min_ext     = {{(CODE_W - VAL_W){min_reg[VAL_W-1]}}, min_reg};
    assign val_ext     = {{(CODE_W - VAL_W){val_reg[VAL_W-1]}}, val_reg};
    assign push_code   = $signed({val_reg[VAL_W-1], val_reg, 1'b0}) - min_ext;
    assign min_restore = $signed({min_reg[VAL_W-1], min_reg, 1'b0}) - top_reg;
    assign top_ge_min  = (top_reg >= min_ext);
    assign top_dec     = top_ge_min ? top_reg[VAL_W-1:0] : min_reg;

    assign stat.needs_load = (cmd_reg == CMD_POP) && (count_reg >= CW'(2));
    assign stat.out_free   = !out_valid_reg || out_ready;

    // operation on the stack state
    always_comb
    begin
        count_next  = count_reg;
        min_next    = min_reg;
        top_next    = top_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        if (cmd.exec)
        begin
            popped_next = '0;
            status_next = ST_OK;
            case (cmd_reg)
                CMD_PUSH:
                begin
                    if (full)
                    begin
                        status_next = ST_OVER;
                    end
                    else if (empty)
                    begin
                        top_next   = val_ext;
                        min_next   = val_reg;
                        count_next = CW'(1);
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (val_reg >= min_reg)
                        begin
                            top_next = val_ext;
                        end
                        else
                        begin
                            top_next = push_code;
                            min_next = val_reg;
                        end
                    end
                end
                CMD_POP:
                begin
                    if (empty)
                    begin
                        status_next = ST_UNDER;
                    end
                    else
                    begin
                        count_next = cnt_m1;
                        mem_re     = stat.needs_load;
                        if (top_ge_min)
                        begin
                            popped_next = top_reg[VAL_W-1:0];
                        end
                        else
                        begin
                            popped_next = min_reg;
                            min_next    = min_restore[VAL_W-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.load)
        begin
            top_next = rd_data_reg;
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_m1[AW-1:0]] <= top_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[cnt_m2[AW-1:0]];
        end
    end

    // item and top registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg <= command;
            val_reg <= push_value;
        end
        top_reg    <= top_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    // count and minimum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            min_reg   <= min_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            popped_out_reg <= popped_reg;
            top_out_reg    <= empty ? '0 : top_dec;
            min_out_reg    <= empty ? '0 : min_reg;
            count_out_reg  <= COUNT_W'(count_reg);
            status_out_reg <= status_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_out_reg;
    assign top_value    = top_out_reg;
    assign min_value    = min_out_reg;
    assign entry_count  = count_out_reg;
    assign status       = status_out_reg;

    // count stays within the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("entry count beyond stack depth");

    // the entry count changes only while an item executes
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(count_reg))
        else $error("entry count changed outside execution");

    // a new result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // underflow leaves an empty stack and pops nothing
    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && cmd_reg == CMD_POP && empty) |=>
            (status_reg == ST_UNDER && popped_reg == '0 && count_reg == '0))
        else $error("bad underflow result");

endmodule

`default_nettype wire

// ===== hdl/min_tracking_stack.sv =====
`default_nettype none

// channel   direction  handshake              payload
// input     in         in_valid / in_ready    command, push_value
// output    out        out_valid / out_ready  popped_value, top_value, min_value,
//                                             entry_count, status
//
// an item passes idle, execute and finish before the next acceptance, its
// result loaded in finish; a pop that leaves entries adds a load state for the
// registered read of the entry memory between execute and finish
// the top code is held in a register, so only pops wait on the memory port
// a waiting result does not block acceptance, but the next item holds in finish
// until it is taken; reset (rst_n low, asynchronous) empties the stack

module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                command,
    input  wire logic signed [VAL_W-1:0]   push_value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [VAL_W-1:0]        popped_value,
    output logic signed [VAL_W-1:0]        top_value,
    output logic signed [VAL_W-1:0]        min_value,
    output logic [COUNT_W-1:0]             entry_count,
    output logic [1:0]                     status
);

    mts_cmd_t  cmd;
    mts_stat_t stat;

    // sequencing of one item
    mts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stack storage, minimum tracking and result register
    mts_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .command      (command),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_value (popped_value),
        .top_value    (top_value),
        .min_value    (min_value),
        .entry_count  (entry_count),
        .status       (status)
    );

endmodule

`default_nettype wire
